FILE: rtl/assert_macros.svh
// assertion macros shared by the lru key cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define LKC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define LKC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LKC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lkc_pkg.sv
// types, codes and widths shared by the lru key cache rtl
package lkc_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 32;
  localparam int CNT_W    = 5;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int STAT_W   = 64;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CNT_W-1:0]    rank_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [ST_W-1:0]     status_t;
  typedef logic [STAT_W-1:0]   stat_t;

  // operation codes
  localparam op_t OP_GET       = 3'd0;
  localparam op_t OP_PUT       = 3'd1;
  localparam op_t OP_REMOVE    = 3'd2;
  localparam op_t OP_EVICT     = 3'd3;
  localparam op_t OP_CLEAR     = 3'd4;
  localparam op_t OP_STATS_RST = 3'd5;

  // status codes
  localparam status_t STS_OK        = 2'd0;
  localparam status_t STS_NOT_FOUND = 2'd1;
  localparam status_t STS_NULL      = 2'd2;
  localparam status_t STS_EMPTY     = 2'd3;

  // recency update applied during the rank sweep
  typedef enum logic [1:0] {
    UPD_NONE      = 2'd0,
    UPD_PROMOTE   = 2'd1,
    UPD_INC_ALL   = 2'd2,
    UPD_DEC_ABOVE = 2'd3
  } upd_mode_t;

  // one entry as read from the store
  typedef struct packed {
    logic    valid;
    key_t    key;
    handle_t handle;
    rank_t   rank;
  } ent_t;

  // controls for the shared compare unit
  typedef struct packed {
    key_t      key;
    upd_mode_t mode;
    rank_t     thr;
    rank_t     last;
    logic      any;
  } ctl_t;

  // compare unit results
  typedef struct packed {
    logic  match;
    logic  oldest;
    logic  free;
    logic  rank_we;
    rank_t new_rank;
    logic  new_oldest;
    key_t  new_old_key;
  } cmp_t;

  // valid bit updates
  typedef struct packed {
    logic set;
    logic clr;
    logic clear_all;
  } vop_t;

endpackage

FILE: rtl/lkc_ifs.sv
// valid/ready channel interfaces for the lru key cache requests and results
interface lkc_in_if;
  import lkc_pkg::*;

  logic    valid;
  logic    ready;
  op_t     op;
  key_t    key;
  handle_t handle_in;

  modport source (output valid, op, key, handle_in, input ready);
  modport sink   (input valid, op, key, handle_in, output ready);
endinterface

interface lkc_out_if;
  import lkc_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  handle_t handle_out;
  logic    evicted_valid;
  key_t    evicted_key;
  cnt_t    occupancy;
  key_t    oldest_key;
  stat_t   hits;
  stat_t   misses;

  modport source (output valid, status, handle_out, evicted_valid, evicted_key,
                  occupancy, oldest_key, hits, misses, input ready);
  modport sink   (input valid, status, handle_out, evicted_valid, evicted_key,
                  occupancy, oldest_key, hits, misses, output ready);
endinterface

FILE: rtl/lkc_entry_store.sv
// entry store: key, handle and rank memories plus per-entry valid bits
`include "assert_macros.svh"

module lkc_entry_store #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IW-1:0]        rd_addr,
  output lkc_pkg::ent_t        ent_o,
  input  logic                 kh_we,
  input  logic [IW-1:0]        kh_addr,
  input  lkc_pkg::key_t        kh_key,
  input  lkc_pkg::handle_t     kh_handle,
  input  logic                 rk_we,
  input  logic [IW-1:0]        rk_addr,
  input  lkc_pkg::rank_t       rk_val,
  input  lkc_pkg::vop_t        vop,
  input  logic [IW-1:0]        set_addr,
  input  logic [IW-1:0]        clr_addr
);
  import lkc_pkg::*;

  key_t    key_mem    [ENTRIES];
  handle_t handle_mem [ENTRIES];
  rank_t   rank_mem   [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (kh_we) begin
      key_mem[kh_addr]    <= kh_key;
      handle_mem[kh_addr] <= kh_handle;
    end
    if (rk_we) begin
      rank_mem[rk_addr] <= rk_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    ent_o.valid  <= valid_r[rd_addr];
    ent_o.key    <= key_mem[rd_addr];
    ent_o.handle <= handle_mem[rd_addr];
    ent_o.rank   <= rank_mem[rd_addr];
  end

  // set after clear so a slot reused in the same cycle ends valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (vop.clear_all) begin
      valid_r <= '0;
    end else begin
      if (vop.clr) begin
        valid_r[clr_addr] <= 1'b0;
      end
      if (vop.set) begin
        valid_r[set_addr] <= 1'b1;
      end
    end
  end

  `LKC_ASSERT_IMP(a_set_free, clk, rst_n, vop.set && !vop.clear_all, !valid_r[set_addr] || (vop.clr && clr_addr == set_addr), "insert into an occupied slot")

endmodule

FILE: rtl/lkc_cmp_unit.sv
// shared compare unit: key match, oldest test and rank update for one entry
module lkc_cmp_unit #(
  parameter int IW = 4
) (
  input  lkc_pkg::ent_t  ent,
  input  logic [IW-1:0]  idx,
  input  lkc_pkg::ctl_t  ctl,
  input  logic           zero_en,
  input  logic [IW-1:0]  zero_idx,
  output lkc_pkg::cmp_t  res
);
  import lkc_pkg::*;

  logic zt;

  assign zt = zero_en && (idx == zero_idx);

  always_comb begin
    res.match       = ent.valid && (ent.key == ctl.key);
    res.oldest      = ent.valid && (ent.rank == ctl.last);
    res.free        = !ent.valid;
    res.rank_we     = 1'b0;
    res.new_rank    = ent.rank;
    res.new_old_key = zt ? ctl.key : ent.key;
    if (zt) begin
      // promoted or freshly inserted entry becomes newest
      res.rank_we  = 1'b1;
      res.new_rank = '0;
    end else if (ent.valid) begin
      res.rank_we = 1'b1;
      unique case (ctl.mode)
        UPD_PROMOTE: begin
          if (ent.rank < ctl.thr) res.new_rank = ent.rank + rank_t'(1);
        end
        UPD_INC_ALL: begin
          res.new_rank = ent.rank + rank_t'(1);
        end
        UPD_DEC_ABOVE: begin
          if (ent.rank > ctl.thr) res.new_rank = ent.rank - rank_t'(1);
        end
        default: begin
          res.new_rank = ent.rank;
        end
      endcase
    end
    res.new_oldest = res.rank_we && ctl.any && (res.new_rank == ctl.last);
  end

endmodule

FILE: rtl/lru_key_cache_core.sv
// top level of the fully associative lru key cache
// lru key cache: ENTRIES-deep fully associative key -> handle cache with
// least recently used replacement
// - in_req carries op, key and handle_in; a request is taken when valid and
//   ready are high on a rising edge. ready is high only while the sequencer
//   is idle, so one request is in flight at a time
// - out_rsp returns exactly one result per request: status, handle_out,
//   evicted_valid/evicted_key, occupancy, oldest_key and the wrapping hit
//   and miss counters
// - cfg_we/cfg_data write the capacity register (reset 16); write it only
//   while no request is in flight
// - each request takes two sweeps over the entry store (find key, oldest and
//   free slot; then update ranks) with a decide state between them, then a
//   done state that loads the result and an idle state; a new request is
//   taken only after the last one has left the done state; the single store
//   read port and the shared compare unit serialise each sweep over the entries
// - the result register holds a finished result while the sink stalls; the
//   next request is accepted meanwhile, and its result waits in the done
//   state until the register frees up
// - synchronous reset empties the cache, zeroes the counters and restores
//   capacity; key, handle and rank memories are not cleared
`include "assert_macros.svh"

module lru_key_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lkc_in_if.sink                   in_req,
  lkc_out_if.source                out_rsp,
  input  logic                     cfg_we,
  input  logic [lkc_pkg::CNT_W-1:0] cfg_data
);
  import lkc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0]   N_CNT    = (IW+1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  // capacity saturates at the store depth and at the register range
  localparam cnt_t CAP_MAX = cnt_t'((ENTRIES < 31) ? ENTRIES : 31);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // sweep counter and read pipeline
  logic [IW:0]   cnt_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic [IW-1:0] rd_addr;
  logic          sweep_end;

  // captured request
  op_t     op_r;
  key_t    key_r;
  handle_t hin_r;

  // architectural state
  cnt_t  cap_r;
  cnt_t  cap_eff;
  cnt_t  count_r;
  stat_t hits_r;
  stat_t misses_r;

  // scan results: matching entry, oldest entry, first free slot
  logic          mf_r, of_r, ff_r;
  logic [IW-1:0] m_idx_r, o_idx_r, f_idx_r;
  rank_t         m_rank_r;
  handle_t       m_hnd_r, o_hnd_r;
  key_t          o_key_r;

  // decisions held for the rank sweep and the result
  upd_mode_t     mode_r;
  rank_t         thr_r;
  logic          zero_en_r;
  logic [IW-1:0] zero_idx_r;
  status_t       sts_r;
  handle_t       hout_r;
  logic          evv_r;
  key_t          evk_r;
  key_t          nok_r;

  // result register
  logic    out_valid_r;
  status_t out_sts_r;
  handle_t out_hout_r;
  logic    out_evv_r;
  key_t    out_evk_r;
  cnt_t    out_occ_r;
  key_t    out_old_r;
  stat_t   out_hits_r;
  stat_t   out_miss_r;

  // decide-cycle combinational outputs
  status_t       d_sts;
  handle_t       d_hout;
  logic          d_evv;
  key_t          d_evk;
  upd_mode_t     d_mode;
  rank_t         d_thr;
  logic          d_zero_en;
  logic [IW-1:0] d_zero_idx;
  vop_t          d_vop;
  logic [IW-1:0] d_set_addr, d_clr_addr;
  logic          d_kh_we;
  cnt_t          d_count;
  logic          d_hit, d_miss, d_stats_clr;
  logic          evict;
  logic [IW-1:0] ins_idx;

  vop_t  vop;
  ent_t  ent;
  ctl_t  ctl;
  cmp_t  cmp;
  logic  out_free;

  assign in_req.ready = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign rd_addr      = (cnt_r < N_CNT) ? cnt_r[IW-1:0] : '0;
  assign sweep_end    = pv_r && (pidx_r == LAST_IDX);

  always_comb begin
    if (cap_r == '0)          cap_eff = cnt_t'(1);
    else if (cap_r > CAP_MAX) cap_eff = CAP_MAX;
    else                      cap_eff = cap_r;
  end

  // count_r - 1 is the oldest rank before the decide cycle and after it
  assign ctl.key  = key_r;
  assign ctl.mode = mode_r;
  assign ctl.thr  = thr_r;
  assign ctl.last = count_r - cnt_t'(1);
  assign ctl.any  = (count_r != '0);

  lkc_entry_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .ent_o     (ent),
    .kh_we     (d_kh_we && (state_r == ST_DECIDE)),
    .kh_addr   (ins_idx),
    .kh_key    (key_r),
    .kh_handle (hin_r),
    .rk_we     ((state_r == ST_UPDATE) && pv_r && cmp.rank_we),
    .rk_addr   (pidx_r),
    .rk_val    (cmp.new_rank),
    .vop       (vop),
    .set_addr  (d_set_addr),
    .clr_addr  (d_clr_addr)
  );

  lkc_cmp_unit #(
    .IW (IW)
  ) u_cmp (
    .ent      (ent),
    .idx      (pidx_r),
    .ctl      (ctl),
    .zero_en  (zero_en_r),
    .zero_idx (zero_idx_r),
    .res      (cmp)
  );

  assign vop.set       = d_vop.set && (state_r == ST_DECIDE);
  assign vop.clr       = d_vop.clr && (state_r == ST_DECIDE);
  assign vop.clear_all = d_vop.clear_all && (state_r == ST_DECIDE);

  // put of a new key: evict the oldest when full, reuse the lower slot
  assign evict   = (count_r >= cap_eff) && of_r;
  assign ins_idx = (evict && (!ff_r || (o_idx_r < f_idx_r))) ? o_idx_r : f_idx_r;

  // decide: act on the scan results
  always_comb begin
    d_sts       = STS_OK;
    d_hout      = '0;
    d_evv       = 1'b0;
    d_evk       = '0;
    d_mode      = UPD_NONE;
    d_thr       = '0;
    d_zero_en   = 1'b0;
    d_zero_idx  = m_idx_r;
    d_vop       = '0;
    d_set_addr  = ins_idx;
    d_clr_addr  = m_idx_r;
    d_kh_we     = 1'b0;
    d_count     = count_r;
    d_hit       = 1'b0;
    d_miss      = 1'b0;
    d_stats_clr = 1'b0;
    unique case (op_r)
      OP_GET: begin
        if (mf_r) begin
          d_hout    = m_hnd_r;
          d_mode    = UPD_PROMOTE;
          d_thr     = m_rank_r;
          d_zero_en = 1'b1;
          d_hit     = 1'b1;
        end else begin
          d_sts  = STS_NOT_FOUND;
          d_miss = 1'b1;
        end
      end
      OP_PUT: begin
        if (hin_r == '0) begin
          d_sts = STS_NULL;
        end else if (mf_r) begin
          d_mode    = UPD_PROMOTE;
          d_thr     = m_rank_r;
          d_zero_en = 1'b1;
        end else begin
          d_mode = UPD_INC_ALL;
          if (evict) begin
            d_evv      = 1'b1;
            d_evk      = o_key_r;
            d_hout     = o_hnd_r;
            d_vop.clr  = 1'b1;
            d_clr_addr = o_idx_r;
          end
          if (evict || ff_r) begin
            d_vop.set  = 1'b1;
            d_kh_we    = 1'b1;
            d_zero_en  = 1'b1;
            d_zero_idx = ins_idx;
            d_count    = evict ? count_r : count_r + cnt_t'(1);
          end else if (evict) begin
            d_count = count_r - cnt_t'(1);
          end
        end
      end
      OP_REMOVE: begin
        if (mf_r) begin
          d_vop.clr = 1'b1;
          d_count   = count_r - cnt_t'(1);
          d_mode    = UPD_DEC_ABOVE;
          d_thr     = m_rank_r;
        end else begin
          d_sts = STS_NOT_FOUND;
        end
      end
      OP_EVICT: begin
        if (of_r) begin
          d_evv      = 1'b1;
          d_evk      = o_key_r;
          d_hout     = o_hnd_r;
          d_vop.clr  = 1'b1;
          d_clr_addr = o_idx_r;
          d_count    = count_r - cnt_t'(1);
        end else begin
          d_sts = STS_EMPTY;
        end
      end
      OP_CLEAR: begin
        d_vop.clear_all = 1'b1;
        d_count         = '0;
      end
      OP_STATS_RST: begin
        d_stats_clr = 1'b1;
      end
      default: begin
        // unused op codes leave everything alone
        d_sts = STS_OK;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_req.valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (sweep_end)    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_UPDATE;
      ST_UPDATE: if (sweep_end)    state_nxt = ST_DONE;
      ST_DONE:   if (out_free)     state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      cap_r    <= cnt_t'(16);
      count_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      unique case (state_r)
        ST_SCAN, ST_UPDATE: begin
          if (cnt_r < N_CNT) cnt_r <= cnt_r + (IW+1)'(1);
          pv_r <= (cnt_r < N_CNT);
        end
        ST_DECIDE: begin
          cnt_r   <= '0;
          pv_r    <= 1'b0;
          count_r <= d_count;
          if (d_stats_clr) begin
            hits_r   <= '0;
            misses_r <= '0;
          end else begin
            if (d_hit)  hits_r   <= hits_r + stat_t'(1);
            if (d_miss) misses_r <= misses_r + stat_t'(1);
          end
        end
        default: begin
          cnt_r <= '0;
          pv_r  <= 1'b0;
        end
      endcase
    end
  end

  // request capture, scan bookkeeping, decisions and rank sweep results
  always_ff @(posedge clk) begin
    pidx_r <= rd_addr;
    unique case (state_r)
      ST_IDLE: begin
        op_r  <= in_req.op;
        key_r <= in_req.key;
        hin_r <= in_req.handle_in;
        mf_r  <= 1'b0;
        of_r  <= 1'b0;
        ff_r  <= 1'b0;
      end
      ST_SCAN: begin
        if (pv_r) begin
          if (cmp.match && !mf_r) begin
            mf_r     <= 1'b1;
            m_idx_r  <= pidx_r;
            m_rank_r <= ent.rank;
            m_hnd_r  <= ent.handle;
          end
          if (cmp.oldest && !of_r) begin
            of_r    <= 1'b1;
            o_idx_r <= pidx_r;
            o_key_r <= ent.key;
            o_hnd_r <= ent.handle;
          end
          if (cmp.free && !ff_r) begin
            ff_r    <= 1'b1;
            f_idx_r <= pidx_r;
          end
        end
      end
      ST_DECIDE: begin
        mode_r     <= d_mode;
        thr_r      <= d_thr;
        zero_en_r  <= d_zero_en;
        zero_idx_r <= d_zero_idx;
        sts_r      <= d_sts;
        hout_r     <= d_hout;
        evv_r      <= d_evv;
        evk_r      <= d_evk;
        nok_r      <= '0;
      end
      ST_UPDATE: begin
        if (pv_r && cmp.new_oldest) nok_r <= cmp.new_old_key;
      end
      default: begin
        nok_r <= nok_r;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_sts_r  <= sts_r;
      out_hout_r <= hout_r;
      out_evv_r  <= evv_r;
      out_evk_r  <= evk_r;
      out_occ_r  <= count_r;
      out_old_r  <= nok_r;
      out_hits_r <= hits_r;
      out_miss_r <= misses_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_sts_r;
  assign out_rsp.handle_out    = out_hout_r;
  assign out_rsp.evicted_valid = out_evv_r;
  assign out_rsp.evicted_key   = out_evk_r;
  assign out_rsp.occupancy     = out_occ_r;
  assign out_rsp.oldest_key    = out_old_r;
  assign out_rsp.hits          = out_hits_r;
  assign out_rsp.misses        = out_miss_r;

  `LKC_ASSERT(a_count_bound, clk, rst_n, count_r <= CAP_MAX, "occupancy above capacity limit")
  `LKC_ASSERT_NXT(a_hit_count, clk, rst_n, (state_r == ST_DECIDE) && (op_r == OP_GET) && mf_r, hits_r == $past(hits_r) + stat_t'(1), "get hit not counted")
  `LKC_ASSERT_NXT(a_result_load, clk, rst_n, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE), "finished request not presented")

endmodule

FILE: tb/lkc_result_checker.sv
`timescale 1ns / 100ps
// result checker for the lru key cache: follows requests, predicts each result and compares
module lkc_result_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lkc_in_if                         req_mon,
  lkc_out_if                        rsp_mon,
  input  logic                      cfg_we,
  input  logic [lkc_pkg::CNT_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        rsp_outstanding
);
  import lkc_pkg::*;

  localparam cnt_t CAP_AFTER_RESET = 5'd16;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } slot_t;

  typedef struct packed {
    status_t status;
    handle_t handle_out;
    logic    evicted_valid;
    key_t    evicted_key;
    cnt_t    occupancy;
    key_t    oldest_key;
    stat_t   hits;
    stat_t   misses;
  } rsp_t;

  // recency order, newest at the front, oldest at the back
  slot_t lru_order[$];
  rsp_t  pending_rsp[$];
  stat_t hit_total;
  stat_t miss_total;
  cnt_t  capacity_reg;
  int    fail_total = 0;
  int    queued_n = 0;
  int    rsp_seq = 0;

  assign mismatches      = fail_total;
  assign rsp_outstanding = queued_n;

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_total++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %h want %h", rsp_seq, name, got, want));
  endtask

  function automatic int find_slot(key_t k);
    foreach (lru_order[i])
      if (lru_order[i].key == k) return i;
    return -1;
  endfunction

  function automatic void bump_to_newest(int idx);
    slot_t s;
    s = lru_order[idx];
    lru_order.delete(idx);
    lru_order.push_front(s);
  endfunction

  // applies one request to the cache image and returns the result it should give
  function automatic rsp_t cache_step(op_t op, key_t k, handle_t h);
    rsp_t        r;
    int          idx;
    slot_t       s;
    int unsigned cap;
    r   = '0;
    cap = 32'(capacity_reg);
    if (cap == 0) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    case (op)
      OP_GET: begin
        idx = find_slot(k);
        if (idx >= 0) begin
          r.handle_out = lru_order[idx].handle;
          bump_to_newest(idx);
          hit_total++;
        end else begin
          r.status = STS_NOT_FOUND;
          miss_total++;
        end
      end
      OP_PUT: begin
        if (h == '0) begin
          r.status = STS_NULL;
        end else begin
          idx = find_slot(k);
          if (idx >= 0) begin
            bump_to_newest(idx);
          end else begin
            // a lowered capacity still costs only one eviction per put
            if (lru_order.size() >= cap) begin
              s = lru_order[$];
              lru_order.delete(lru_order.size() - 1);
              r.evicted_valid = 1'b1;
              r.evicted_key   = s.key;
              r.handle_out    = s.handle;
            end
            s.key    = k;
            s.handle = h;
            lru_order.push_front(s);
          end
        end
      end
      OP_REMOVE: begin
        idx = find_slot(k);
        if (idx >= 0) lru_order.delete(idx);
        else r.status = STS_NOT_FOUND;
      end
      OP_EVICT: begin
        if (lru_order.size() > 0) begin
          s = lru_order[$];
          lru_order.delete(lru_order.size() - 1);
          r.evicted_valid = 1'b1;
          r.evicted_key   = s.key;
          r.handle_out    = s.handle;
        end else begin
          r.status = STS_EMPTY;
        end
      end
      OP_CLEAR: lru_order.delete();
      OP_STATS_RST: begin
        hit_total  = '0;
        miss_total = '0;
      end
      default: ;
    endcase
    r.occupancy  = cnt_t'(lru_order.size());
    r.oldest_key = (lru_order.size() > 0) ? lru_order[$].key : '0;
    r.hits       = hit_total;
    r.misses     = miss_total;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      lru_order.delete();
      pending_rsp.delete();
      hit_total    = '0;
      miss_total   = '0;
      capacity_reg = CAP_AFTER_RESET;
    end else begin
      if (cfg_we) capacity_reg = cfg_data;
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_rsp.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request pending", rsp_seq));
        end else begin
          want = pending_rsp.pop_front();
          check_field("status", 64'(rsp_mon.status), 64'(want.status));
          check_field("handle_out", 64'(rsp_mon.handle_out), 64'(want.handle_out));
          check_field("evicted_valid", 64'(rsp_mon.evicted_valid), 64'(want.evicted_valid));
          check_field("evicted_key", rsp_mon.evicted_key, want.evicted_key);
          check_field("occupancy", 64'(rsp_mon.occupancy), 64'(want.occupancy));
          check_field("oldest_key", rsp_mon.oldest_key, want.oldest_key);
          check_field("hits", rsp_mon.hits, want.hits);
          check_field("misses", rsp_mon.misses, want.misses);
        end
        rsp_seq++;
      end
      if (req_mon.valid && req_mon.ready)
        pending_rsp = {pending_rsp, cache_step(req_mon.op, req_mon.key, req_mon.handle_in)};
    end
    queued_n <= pending_rsp.size();
  end

endmodule

FILE: tb/tb_lru_key_cache_core.sv
`timescale 1ns / 100ps
// top of the lru key cache testbench: clock, reset, request stimulus, result pacing, verdict
module tb_lru_key_cache_core;
  import lkc_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int KEY_POOL       = 24;   // more keys than entries so misses and evictions happen
  localparam int HOLD_CYCLES    = 400;  // long result back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000; // cycles with no handshake on either channel
  localparam int DRAIN_CYCLES   = 2 * ENTRIES + 8;

  // op codes the block ignores
  localparam op_t OP_UNUSED_LO = 3'd6;
  localparam op_t OP_UNUSED_HI = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  int               fail_count;
  int               outstanding;

  // stimulus settings; hold_asks is also shared with the result pacing
  bit   burst_mode = 1'b0;
  int   hold_asks = 0;
  key_t key_pool[KEY_POOL];

  lkc_in_if  req_if ();
  lkc_out_if rsp_if ();

  lru_key_cache_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  lkc_result_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatches     (fail_count),
    .rsp_outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one request after a random gap and hold it until the block takes it;
  // valid stays high when the next request follows with no gap
  task automatic send_req(op_t op, key_t k, handle_t h);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.key       <= k;
    req_if.handle_in <= h;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // stop offering and wait until every pending result has been taken
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // capacity is only written with nothing in flight
  task automatic set_capacity(cnt_t cap);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // one random phase at a given capacity; fill phases lean on puts so the
  // cache gets full, squeeze asks the result side for a long hold-off
  task automatic run_phase(cnt_t cap, bit fill, bit burst, bit squeeze, int n_items);
    int      done;
    int      r;
    op_t     op;
    key_t    k;
    handle_t h;
    set_capacity(cap);
    burst_mode = burst;
    if (squeeze) hold_asks++;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (fill)
        op = (r < 75) ? OP_PUT : (r < 93) ? OP_GET : OP_REMOVE;
      else
        op = (r < 30) ? OP_GET :
             (r < 62) ? OP_PUT :
             (r < 74) ? OP_REMOVE :
             (r < 82) ? OP_EVICT :
             (r < 85) ? OP_CLEAR :
             (r < 89) ? OP_STATS_RST :
             (r < 94) ? OP_UNUSED_LO : OP_UNUSED_HI;
      // mostly keys from the pool so gets and puts hit, some fresh random keys
      k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                      : {$urandom, $urandom};
      r = $urandom_range(0, 99);
      h = (r < 6) ? handle_t'(0) :
          (r < 10) ? '1 : handle_t'($urandom_range(1, 32'hffff_ffff));
      send_req(op, k, h);
      // ignored op codes do not count toward the phase length
      if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) done++;
    end
    burst_mode = 1'b0;
  endtask

  // request stimulus
  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    req_if.valid     <= 1'b0;
    req_if.op        <= OP_GET;
    req_if.key       <= '0;
    req_if.handle_in <= '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h5555_5555_5555_5555;
    key_pool[3] = 64'haaaa_aaaa_aaaa_aaaa;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset capacity
    send_req(OP_EVICT, '0, '0);                             // evict on an empty cache
    send_req(OP_GET, '0, '0);                               // miss
    send_req(OP_REMOVE, '1, '0);                            // remove of an absent key
    send_req(OP_PUT, 64'h1, '0);                            // null handle rejected
    send_req(OP_PUT, '0, '1);
    send_req(OP_PUT, '1, 32'h1);
    send_req(OP_PUT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    send_req(OP_GET, '0, '0);                               // hit, promotes key zero
    send_req(OP_PUT, '1, 32'h1234);                         // held key keeps its handle
    send_req(OP_GET, '1, '0);
    send_req(OP_UNUSED_LO, 64'h7, 32'h7);
    send_req(OP_UNUSED_HI, '1, '1);
    send_req(OP_STATS_RST, '0, '0);
    send_req(OP_REMOVE, 64'h5555_5555_5555_5555, '0);
    send_req(OP_EVICT, '0, '0);
    send_req(OP_CLEAR, '0, '0);

    // small capacity: the third new key pushes out the oldest
    set_capacity(5'd2);
    send_req(OP_PUT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
    send_req(OP_PUT, 64'h8000_0000_0000_0001, 32'h8000_0001);
    send_req(OP_PUT, 64'h0123_4567_89ab_cdef, 32'hdead_beef);

    // capacity dropped below occupancy: one eviction only, occupancy holds
    set_capacity(5'd1);
    send_req(OP_PUT, 64'hfedc_ba98_7654_3210, 32'hffff_fffe);
    send_req(OP_GET, 64'h0123_4567_89ab_cdef, '0);
    send_req(OP_EVICT, '0, '0);

    // random part over a range of capacities, extremes and out-of-range codes included
    run_phase(5'd16, 1'b1, 1'b0, 1'b0, 60);
    run_phase(5'd3,  1'b0, 1'b0, 1'b0, 60);
    run_phase(5'd0,  1'b0, 1'b1, 1'b0, 40);
    run_phase(5'd31, 1'b1, 1'b0, 1'b0, 50);
    run_phase(5'd1,  1'b0, 1'b0, 1'b0, 40);
    run_phase(5'd17, 1'b0, 1'b1, 1'b1, 60);
    run_phase(5'd8,  1'b0, 1'b0, 1'b0, 60);
    run_phase(5'd16, 1'b1, 1'b1, 1'b0, 40);
    run_phase(cnt_t'($urandom_range(0, 31)), 1'b0, 1'b0, 1'b0, 90);

    // drain, then let a request latency pass to catch stray results
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // result side pacing: short stalls mostly, a few long ones, open stretches,
  // and the long hold-off when the stimulus asks for it
  initial begin : sink_pacing
    int   r;
    int   run;
    logic lvl;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_asks > 0) begin
        hold_asks--;
        lvl = 1'b0;
        run = HOLD_CYCLES;
      end else if (r < 50) begin
        lvl = 1'b1;
        run = $urandom_range(1, 12);
      end else if (r < 88) begin
        lvl = 1'b0;
        run = $urandom_range(1, 3);
      end else if (r < 95) begin
        lvl = 1'b0;
        run = $urandom_range(20, 80);
      end else begin
        lvl = 1'b1;
        run = $urandom_range(100, 300);
      end
      rsp_if.ready <= lvl;
      repeat (run) @(posedge clk);
    end
  end

  // watchdog: a hang shows as a long run of cycles with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
